>>> design/bpdc_pkg.sv
// Package for the boot packet deframer and checker: constants, codes and types.
`timescale 1ns / 1ps
`default_nettype none

package bpdc_pkg;

  // Framing bytes
  localparam logic [7:0] BYTE_START = 8'h81;
  localparam logic [7:0] BYTE_END   = 8'h03;

  // Largest payload; a length field counts the response code too
  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned LEN_W       = 11;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD + 1);
  // Largest high length byte that can still give a legal length
  localparam logic [7:0] LEN_HI_MAX = 8'((MAX_PAYLOAD + 1) >> 8);

  // Command register
  localparam int unsigned CMD_W = 7;
  localparam logic [CMD_W-1:0] CMD_RESET = 7'h15;

  // Result kinds (travel on tuser)
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  // Packet verdicts
  typedef enum logic [2:0] {
    V_OK     = 3'd0,
    V_START  = 3'd1,
    V_LENGTH = 3'd2,
    V_RESP   = 3'd3,
    V_END    = 3'd4,
    V_SUM    = 3'd5
  } verdict_t;

  // Parser phases, one-hot
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LEN_HI = 8'b0000_0010,
    ST_LEN_LO = 8'b0000_0100,
    ST_RESP   = 8'b0000_1000,
    ST_DATA   = 8'b0001_0000,
    ST_SUM    = 8'b0010_0000,
    ST_END    = 8'b0100_0000,
    ST_HUNT   = 8'b1000_0000
  } state_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    verdict_t    verdict;
    logic        error_response;
  } result_t;

endpackage : bpdc_pkg

`default_nettype wire

>>> design/boot_packet_deframer_checker.sv
// Boot packet deframer and checker: byte parser, checksum and result buffering.
//
// Takes one received link byte per cycle and checks framed packets
// (0x81, length high/low, response code, payload, sum, 0x03). Payload bytes
// leave as kind 0 items; header errors and the end of each packet leave as
// one kind 1 verdict item. Every byte is handled in the cycle it is
// accepted: the parser state, byte counter and 8-bit running sum update at
// that edge, and the result is registered at the same edge, in the output
// register or, while the sink stalls, in the skid entry.
// A byte can be accepted every cycle; an output register plus one skid entry
// absorb a stalled sink, and in_tready drops only while the skid entry is
// full. expected_command may be written only while no packet is in flight.
`timescale 1ns / 1ps
`default_nettype none

module boot_packet_deframer_checker
  import bpdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,   // expected_command
  // Received bytes
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] rx_byte
  // Results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,     // [7:0] payload, [10:8] verdict,
                                          // [11] error_response, [15:12] zero
  output logic             out_tuser      // [0] kind
);

  // Registers
  logic [CMD_W-1:0] cmd_r;
  state_t           state_r, state_nxt;
  logic [2:0]       len_hi_r, len_hi_nxt;
  logic [LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             err_bit_r, err_bit_nxt;
  logic             sum_ok_r, sum_ok_nxt;
  logic             out_valid_r, skid_valid_r;
  result_t          out_r, skid_r;

  // Per-item working values
  logic             in_acc;
  logic             res_valid;
  result_t          res;
  logic [LEN_W-1:0] len_full;
  logic [7:0]       sum_add;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign len_full  = {len_hi_r, in_tdata};
  assign sum_add   = sum_r + in_tdata;

  // Parser: next state and result for the byte at the input
  always_comb begin
    state_nxt      = state_r;
    len_hi_nxt     = len_hi_r;
    bytes_left_nxt = bytes_left_r;
    sum_nxt        = sum_r;
    err_bit_nxt    = err_bit_r;
    sum_ok_nxt     = sum_ok_r;
    res_valid      = 1'b0;
    res            = '{kind: KIND_VERDICT, payload: 8'd0, verdict: V_OK,
                       error_response: 1'b0};
    case (state_r)
      ST_IDLE, ST_HUNT: begin
        if (in_tdata == BYTE_START) begin
          sum_nxt   = 8'd0;
          len_hi_nxt = 3'd0;
          state_nxt = ST_LEN_HI;
        end else if (state_r == ST_IDLE) begin
          // stray byte where a start was due
          state_nxt   = ST_HUNT;
          res_valid   = 1'b1;
          res.verdict = V_START;
        end
      end
      ST_LEN_HI: begin
        sum_nxt = sum_add;
        if (in_tdata > LEN_HI_MAX) begin
          state_nxt   = ST_HUNT;
          res_valid   = 1'b1;
          res.verdict = V_LENGTH;
        end else begin
          len_hi_nxt = in_tdata[2:0];
          state_nxt  = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        sum_nxt = sum_add;
        if (len_full == '0 || len_full > LEN_MAX) begin
          state_nxt   = ST_HUNT;
          res_valid   = 1'b1;
          res.verdict = V_LENGTH;
        end else begin
          // payload count excludes the response code
          bytes_left_nxt = len_full - LEN_W'(1);
          state_nxt      = ST_RESP;
        end
      end
      ST_RESP: begin
        if (in_tdata[6:0] != cmd_r) begin
          state_nxt   = ST_HUNT;
          res_valid   = 1'b1;
          res.verdict = V_RESP;
        end else begin
          sum_nxt     = sum_add;
          err_bit_nxt = in_tdata[7];
          state_nxt   = (bytes_left_r == '0) ? ST_SUM : ST_DATA;
        end
      end
      ST_DATA: begin
        sum_nxt        = sum_add;
        bytes_left_nxt = bytes_left_r - LEN_W'(1);
        if (bytes_left_r == LEN_W'(1)) begin
          state_nxt = ST_SUM;
        end
        res_valid   = 1'b1;
        res.kind    = KIND_PAYLOAD;
        res.payload = in_tdata;
      end
      ST_SUM: begin
        sum_ok_nxt = (sum_add == 8'd0);
        state_nxt  = ST_END;
      end
      ST_END: begin
        state_nxt          = ST_IDLE;
        res_valid          = 1'b1;
        res.error_response = err_bit_r;
        if (in_tdata != BYTE_END) begin
          res.verdict = V_END;
        end else if (!sum_ok_r) begin
          res.verdict = V_SUM;
        end else begin
          res.verdict = V_OK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Config register and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r        <= CMD_RESET;
      state_r      <= ST_IDLE;
      len_hi_r     <= '0;
      bytes_left_r <= '0;
      sum_r        <= '0;
      err_bit_r    <= 1'b0;
      sum_ok_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cmd_r <= cfg_wr_data;
      end
      if (in_acc) begin
        state_r      <= state_nxt;
        len_hi_r     <= len_hi_nxt;
        bytes_left_r <= bytes_left_nxt;
        sum_r        <= sum_nxt;
        err_bit_r    <= err_bit_nxt;
        sum_ok_r     <= sum_ok_nxt;
      end
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_tready) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc && res_valid;
        end
      end else if (in_acc && res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Payload of output and skid entries
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (out_valid_r && !out_tready && in_acc && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {4'd0, out_r.error_response, out_r.verdict, out_r.payload};

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds an item while output register is empty");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_PAYLOAD) |-> (out_tdata[11:8] == 4'd0))
    else $error("payload item carries verdict or error flag");

  a_verdict_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_VERDICT) |-> (out_tdata[7:0] == 8'd0))
    else $error("verdict item carries payload bits");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA) |-> (bytes_left_r != '0 && bytes_left_r <= LEN_MAX))
    else $error("payload counter out of range in data phase");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && state_r == ST_DATA) |=>
      (bytes_left_r == $past(bytes_left_r) - LEN_W'(1)))
    else $error("payload counter did not step on a data item");

endmodule : boot_packet_deframer_checker

`default_nettype wire
